### rtl/stack_with_multipop_defines.svh
// ----------------------------------------------------------------------------
// stack_with_multipop_defines.svh
// Assertion macros for the LIFO stack block; empty bodies under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MULTIPOP_DEFINES_SVH
`define STACK_WITH_MULTIPOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define STK_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define STK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define STK_ASSERT(lbl, cond, msg)
`define STK_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

### rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Shared constants, codes and controller/datapath types of the LIFO stack.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

    // Storage geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths
    localparam int CNT_W = 7;
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_MULTIPOP = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ZERO    = 3'd3,
        ST_CLEARED = 3'd4
    } status_t;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PUSH,
        CMD_STATUS,
        CMD_CLEAR,
        CMD_READ,
        CMD_POP
    } dp_cmd_t;

    typedef struct packed {
        logic    load;
        dp_cmd_t cmd;
        status_t status;
    } ctrl_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    empty;
        logic    full;
        logic    cnt_zero;
        logic    cnt_over;
        logic    rem_one;
        logic    out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/stk_req_if.sv
// ----------------------------------------------------------------------------
// stk_req_if
// Request channel of the stack: opcode, push word and pop count.
// ----------------------------------------------------------------------------
`default_nettype none

interface stk_req_if import stk_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [VAL_W-1:0] push_value;
    logic [CNT_W-1:0] pop_count;

    modport source (output valid, output opcode, output push_value, output pop_count,
                    input ready);
    modport sink   (input valid, input opcode, input push_value, input pop_count,
                    output ready);
endinterface

`default_nettype wire

### rtl/stk_rsp_if.sv
// ----------------------------------------------------------------------------
// stk_rsp_if
// Response channel of the stack: popped word, status and stack view.
// ----------------------------------------------------------------------------
`default_nettype none

interface stk_rsp_if import stk_pkg::*;;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] popped_value;
    logic [ST_W-1:0]  status;
    logic             last;
    logic [CNT_W-1:0] stack_depth;
    logic [VAL_W-1:0] top_value;
    logic             top_valid;

    modport source (output valid, output popped_value, output status, output last,
                    output stack_depth, output top_value, output top_valid,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input last,
                    input stack_depth, input top_value, input top_valid,
                    output ready);
endinterface

`default_nettype wire

### rtl/stk_dp.sv
// ----------------------------------------------------------------------------
// stk_dp
// Stack datapath: entry memory, cached top word, entry count, pop counter
// and the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_with_multipop_defines.svh"

module stk_dp import stk_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [OP_W-1:0]  opcode,
    input  wire logic [VAL_W-1:0] push_value,
    input  wire logic [CNT_W-1:0] pop_count,
    input  wire ctrl_cmd_t        cmd,
    output dp_stat_t              stat,
    stk_rsp_if.source             rsp
);

    logic [VAL_W-1:0] mem [DEPTH];

    opcode_t          op_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] rem_reg,   rem_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0] top_reg,   top_next;
    logic [VAL_W-1:0] rd_data_reg;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_popped_reg;
    status_t          out_status_reg;
    logic             out_last_reg;
    logic [CNT_W-1:0] out_depth_reg;
    logic [VAL_W-1:0] out_top_reg;
    logic             out_top_valid_reg;

    logic             emit;
    logic             we;
    logic             rd_en;
    logic [CNT_W-1:0] rd_ofs;
    logic [CNT_W-1:0] rd_pos;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0] popped;
    status_t          res_status;
    logic             res_last;
    logic             out_free;

    assign out_free = !out_valid_reg || rsp.ready;

    // Read the word just below the top to refill it; during a pop, prefetch the one below that
    assign rd_ofs  = (cmd.cmd == CMD_POP) ? CNT_W'(3) : CNT_W'(2);
    assign rd_pos  = count_reg - rd_ofs;
    assign rd_addr = rd_pos[ADDR_W-1:0];
    assign wr_addr = count_reg[ADDR_W-1:0];

    // Decode the datapath operation
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        rem_next   = rem_reg;
        popped     = '0;
        res_status = ST_OK;
        res_last   = 1'b1;
        emit       = 1'b0;
        we         = 1'b0;
        rd_en      = 1'b0;
        unique case (cmd.cmd)
            CMD_NONE:
            begin
            end
            CMD_PUSH:
            begin
                we         = 1'b1;
                count_next = count_reg + CNT_W'(1);
                top_next   = val_reg;
                emit       = 1'b1;
            end
            CMD_STATUS:
            begin
                res_status = cmd.status;
                emit       = 1'b1;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
                res_status = ST_CLEARED;
                emit       = 1'b1;
            end
            CMD_READ:
            begin
                rd_en = 1'b1;
            end
            CMD_POP:
            begin
                popped     = top_reg;
                top_next   = rd_data_reg;
                count_next = count_reg - CNT_W'(1);
                rem_next   = rem_reg - CNT_W'(1);
                res_last   = (rem_reg == CNT_W'(1));
                rd_en      = 1'b1;
                emit       = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= val_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Latch the accepted request and the cached top word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(opcode);
            val_reg <= push_value;
            cnt_reg <= pop_count;
        end
        top_reg <= top_next;
    end

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                rem_reg <= (opcode_t'(opcode) == OP_POP) ? CNT_W'(1) : pop_count;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
    end

    // Response register: hold until taken, load on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_popped_reg    <= popped;
            out_status_reg    <= res_status;
            out_last_reg      <= res_last;
            out_depth_reg     <= count_next;
            out_top_valid_reg <= (count_next != '0);
            out_top_reg       <= (count_next != '0) ? top_next : '0;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = out_popped_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.last         = out_last_reg;
    assign rsp.stack_depth  = out_depth_reg;
    assign rsp.top_value    = out_top_reg;
    assign rsp.top_valid    = out_top_valid_reg;

    // Status toward the controller
    assign stat.op       = op_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_W'(DEPTH));
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.cnt_over = (cnt_reg > count_reg);
    assign stat.rem_one  = (rem_reg == CNT_W'(1));
    assign stat.out_free = out_free;

    `STK_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `STK_ASSERT_IMPL(a_pop_nonempty, cmd.cmd == CMD_POP, count_reg != '0, "pop on empty stack")
    `STK_ASSERT_IMPL(a_push_room, cmd.cmd == CMD_PUSH, count_reg < CNT_W'(DEPTH), "push when full")
    `STK_ASSERT_IMPL(a_no_overwrite, emit, out_free, "response overwritten before taken")

endmodule

`default_nettype wire

### rtl/stk_ctrl.sv
// ----------------------------------------------------------------------------
// stk_ctrl
// Stack controller: accepts a request, picks the outcome from datapath
// status, and sequences one pop per cycle for pop and multipop while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_ctrl import stk_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output ctrl_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_POP
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Choose the datapath operation and the next state
    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.cmd    = CMD_NONE;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (stat.op)
                    OP_PUSH:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                            if (stat.full)
                            begin
                                cmd.cmd    = CMD_STATUS;
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.cmd = CMD_PUSH;
                            end
                        end
                    end
                    OP_POP:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.cmd    = CMD_READ;
                            state_next = S_POP;
                        end
                        else if (stat.out_free)
                        begin
                            cmd.cmd    = CMD_STATUS;
                            cmd.status = ST_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    OP_MULTIPOP:
                    begin
                        if (!stat.cnt_zero && !stat.empty && !stat.cnt_over)
                        begin
                            cmd.cmd    = CMD_READ;
                            state_next = S_POP;
                        end
                        else if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                            if (stat.cnt_zero)
                            begin
                                cmd.cmd    = CMD_STATUS;
                                cmd.status = ST_ZERO;
                            end
                            else if (stat.empty)
                            begin
                                cmd.cmd    = CMD_STATUS;
                                cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.cmd = CMD_CLEAR;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        if (stat.out_free)
                        begin
                            state_next = S_IDLE;
                            if (stat.empty)
                            begin
                                cmd.cmd    = CMD_STATUS;
                                cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.cmd = CMD_CLEAR;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.cmd = CMD_POP;
                    if (stat.rem_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/stack_with_multipop.sv
// ----------------------------------------------------------------------------
// stack_with_multipop
// Bounded LIFO stack of signed 32-bit words with push, pop, multipop and
// clear; every response reports the resulting depth and top word.
//
//   channel  role    handshake      payload
//   req      sink    valid/ready    opcode, push_value, pop_count
//   rsp      source  valid/ready    popped_value, status, last, stack_depth,
//                                   top_value, top_valid
//
// A request is taken in the idle state and decided in the decide state,
// which waits for a free output register before it emits push, clear and
// single-status outcomes. Pop and multipop first read the word under the
// top from the memory's registered read port, then one word pops per cycle
// while the output is free and the next one is prefetched. A stalled response
// holds in the output register and pauses the pop sequence. Reset empties
// the stack at once; the entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_multipop import stk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    stk_req_if.sink   req,
    stk_rsp_if.source rsp
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;
    logic      in_ready;

    assign req.ready = in_ready;

    // Sequence requests
    stk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold entries and drive responses
    stk_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (req.opcode),
        .push_value (req.push_value),
        .pop_count  (req.pop_count),
        .cmd        (cmd),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
